// File: rtl/abp_pkg.sv
// Shared types, widths and helpers for the alpha blend pixel pipeline.
// No dependencies; used by abp_div and alpha_blend_pixel_top.
`timescale 1ns / 1ps

package abp_pkg;

    localparam int ChanW     = 8;
    localparam int CoordW    = 12;
    localparam int NumW      = 2 * ChanW;
    localparam int DivStages = ChanW;

    localparam logic [ChanW-1:0] ChanMax = '1;
    localparam logic [ChanW-1:0] ChanMin = '0;

    localparam logic CmdSet   = 1'b0;
    localparam logic CmdBlend = 1'b1;

    // How the result of a request is formed.
    typedef enum logic [1:0] {
        SEL_SKIP,
        SEL_RAW,
        SEL_OPAQUE,
        SEL_MIX
    } t_sel;

    typedef struct packed {
        logic [ChanW-1:0]  src_r;
        logic [ChanW-1:0]  src_g;
        logic [ChanW-1:0]  src_b;
        logic [ChanW-1:0]  src_a;
        logic [ChanW-1:0]  dst_r;
        logic [ChanW-1:0]  dst_g;
        logic [ChanW-1:0]  dst_b;
        logic [ChanW-1:0]  dst_a;
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
    } t_pix;

    // What rides alongside the divider stages.
    typedef struct packed {
        t_sel              sel;
        logic [ChanW-1:0]  src_r;
        logic [ChanW-1:0]  src_g;
        logic [ChanW-1:0]  src_b;
        logic [ChanW-1:0]  src_a;
        logic [ChanW-1:0]  oa;
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
    } t_tail;

    // Round to nearest of p / 255 for p up to 255 * 255.
    // x / 255 == (x + (x >> 8) + 1) >> 8 while the quotient stays below 256.
    function automatic logic [ChanW-1:0] rdiv255(input logic [NumW-1:0] p);
        logic [NumW:0] x;
        logic [NumW:0] t;
        x = {1'b0, p} + (NumW+1)'(127);
        t = x + {{ChanW{1'b0}}, x[NumW:ChanW]} + (NumW+1)'(1);
        return t[NumW-1:ChanW];
    endfunction

endpackage

// File: rtl/abp_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on abp_pkg; numerator must be below 256 times the divisor.
`timescale 1ns / 1ps

module abp_div (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [abp_pkg::NumW-1:0]     i_num,
    input  logic [abp_pkg::ChanW-1:0]    i_den,
    output logic [abp_pkg::ChanW-1:0]    o_quo
);

    localparam int W = abp_pkg::ChanW;
    localparam int N = abp_pkg::DivStages;

    logic [W-1:0] r_rem [N];
    logic [W-1:0] r_low [N];
    logic [W-1:0] r_den [N];
    logic [W-1:0] r_quo [N];

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_stage
            logic [W-1:0] w_rem_in;
            logic [W-1:0] w_low_in;
            logic [W-1:0] w_den_in;
            logic [W-1:0] w_quo_in;
            logic [W:0]   w_trial;
            logic         w_ge;

            if (k == 0) begin : g_first
                // High half is already below the divisor.
                assign w_rem_in = i_num[2*W-1:W];
                assign w_low_in = i_num[W-1:0];
                assign w_den_in = i_den;
                assign w_quo_in = '0;
            end else begin : g_next
                assign w_rem_in = r_rem[k-1];
                assign w_low_in = r_low[k-1];
                assign w_den_in = r_den[k-1];
                assign w_quo_in = r_quo[k-1];
            end

            assign w_trial = {w_rem_in, w_low_in[W-1]};
            assign w_ge    = (w_trial >= {1'b0, w_den_in});

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_ge ? W'(w_trial - {1'b0, w_den_in}) : w_trial[W-1:0];
                    r_low[k] <= {w_low_in[W-2:0], 1'b0};
                    r_den[k] <= w_den_in;
                    r_quo[k] <= {w_quo_in[W-2:0], w_ge};
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[N-1];

endmodule

// File: rtl/alpha_blend_pixel_top.sv
// Throughput: one request per cycle while the output is not stalled; five
// arithmetic stages, then an eight-stage bit-per-cycle divider per color channel,
// then the output register.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset (synchronous, active low) clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps

module alpha_blend_pixel_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_cmd,
    input  logic [abp_pkg::ChanW-1:0]     i_src_r,
    input  logic [abp_pkg::ChanW-1:0]     i_src_g,
    input  logic [abp_pkg::ChanW-1:0]     i_src_b,
    input  logic [abp_pkg::ChanW-1:0]     i_src_a,
    input  logic [abp_pkg::ChanW-1:0]     i_dst_r,
    input  logic [abp_pkg::ChanW-1:0]     i_dst_g,
    input  logic [abp_pkg::ChanW-1:0]     i_dst_b,
    input  logic [abp_pkg::ChanW-1:0]     i_dst_a,
    input  logic [abp_pkg::ChanW-1:0]     i_coverage,
    input  logic [abp_pkg::CoordW-1:0]    i_pixel_x,
    input  logic [abp_pkg::CoordW-1:0]    i_pixel_y,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_write_enable,
    output logic [abp_pkg::ChanW-1:0]     o_out_r,
    output logic [abp_pkg::ChanW-1:0]     o_out_g,
    output logic [abp_pkg::ChanW-1:0]     o_out_b,
    output logic [abp_pkg::ChanW-1:0]     o_out_a,
    output logic [abp_pkg::CoordW-1:0]    o_out_x,
    output logic [abp_pkg::CoordW-1:0]    o_out_y
);

    localparam int W  = abp_pkg::ChanW;
    localparam int NW = abp_pkg::NumW;
    localparam int N  = abp_pkg::DivStages;

    logic w_en;

    // Hold everything while a finished request waits on the output.
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    // Stage 1: coverage product and early decisions.
    logic           r_v1;
    abp_pkg::t_pix  r_s1_pix;
    logic [NW-1:0]  r_s1_p;
    abp_pkg::t_sel  r_s1_pre;
    abp_pkg::t_sel  w_pre;

    always_comb begin
        if (i_coverage == abp_pkg::ChanMin) begin
            w_pre = abp_pkg::SEL_SKIP;
        end else if (i_cmd == abp_pkg::CmdSet && i_coverage == abp_pkg::ChanMax) begin
            w_pre = abp_pkg::SEL_RAW;
        end else if (i_cmd == abp_pkg::CmdBlend && i_src_a == abp_pkg::ChanMin) begin
            w_pre = abp_pkg::SEL_SKIP;
        end else begin
            w_pre = abp_pkg::SEL_MIX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_pix <= '{src_r: i_src_r, src_g: i_src_g, src_b: i_src_b, src_a: i_src_a,
                          dst_r: i_dst_r, dst_g: i_dst_g, dst_b: i_dst_b, dst_a: i_dst_a,
                          x: i_pixel_x, y: i_pixel_y};
            r_s1_p   <= NW'(i_src_a) * NW'(i_coverage);
            r_s1_pre <= w_pre;
        end
    end

    // Stage 2: faded alpha and final selection.
    logic           r_v2;
    abp_pkg::t_pix  r_s2_pix;
    logic [W-1:0]   r_s2_fa;
    abp_pkg::t_sel  r_s2_sel;
    logic [W-1:0]   w_fa;
    abp_pkg::t_sel  w_sel;

    assign w_fa = abp_pkg::rdiv255(r_s1_p);

    always_comb begin
        w_sel = r_s1_pre;
        if (r_s1_pre == abp_pkg::SEL_MIX) begin
            if (w_fa == abp_pkg::ChanMin) begin
                w_sel = abp_pkg::SEL_SKIP;
            end else if (w_fa == abp_pkg::ChanMax) begin
                w_sel = abp_pkg::SEL_OPAQUE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_pix <= r_s1_pix;
            r_s2_fa  <= w_fa;
            r_s2_sel <= w_sel;
        end
    end

    // Stage 3: destination weight product.
    logic           r_v3;
    abp_pkg::t_pix  r_s3_pix;
    logic [W-1:0]   r_s3_fa;
    abp_pkg::t_sel  r_s3_sel;
    logic [NW-1:0]  r_s3_dp;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_pix <= r_s2_pix;
            r_s3_fa  <= r_s2_fa;
            r_s3_sel <= r_s2_sel;
            r_s3_dp  <= NW'(r_s2_pix.dst_a) * NW'(abp_pkg::ChanMax - r_s2_fa);
        end
    end

    // Stage 4: destination contribution and result alpha.
    logic           r_v4;
    abp_pkg::t_pix  r_s4_pix;
    logic [W-1:0]   r_s4_fa;
    abp_pkg::t_sel  r_s4_sel;
    logic [W-1:0]   r_s4_dc;
    logic [W-1:0]   r_s4_oa;
    logic [W-1:0]   w_dc;
    logic [W:0]     w_oa_sum;

    assign w_dc     = abp_pkg::rdiv255(r_s3_dp);
    assign w_oa_sum = {1'b0, r_s3_fa} + {1'b0, w_dc};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_pix <= r_s3_pix;
            r_s4_fa  <= r_s3_fa;
            r_s4_sel <= r_s3_sel;
            r_s4_dc  <= w_dc;
            r_s4_oa  <= w_oa_sum[W] ? abp_pkg::ChanMax : w_oa_sum[W-1:0];
        end
    end

    // Stage 5: rounded numerators per channel.
    logic           r_v5;
    abp_pkg::t_tail r_s5_tail;
    logic [NW-1:0]  r_s5_nr;
    logic [NW-1:0]  r_s5_ng;
    logic [NW-1:0]  r_s5_nb;
    logic [NW:0]    w_nr;
    logic [NW:0]    w_ng;
    logic [NW:0]    w_nb;
    logic [NW:0]    w_half;

    assign w_half = (NW+1)'(r_s4_oa >> 1);
    assign w_nr   = (NW+1)'(NW'(r_s4_pix.src_r) * NW'(r_s4_fa))
                  + (NW+1)'(NW'(r_s4_pix.dst_r) * NW'(r_s4_dc)) + w_half;
    assign w_ng   = (NW+1)'(NW'(r_s4_pix.src_g) * NW'(r_s4_fa))
                  + (NW+1)'(NW'(r_s4_pix.dst_g) * NW'(r_s4_dc)) + w_half;
    assign w_nb   = (NW+1)'(NW'(r_s4_pix.src_b) * NW'(r_s4_fa))
                  + (NW+1)'(NW'(r_s4_pix.dst_b) * NW'(r_s4_dc)) + w_half;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5_tail <= '{sel: r_s4_sel, src_r: r_s4_pix.src_r, src_g: r_s4_pix.src_g,
                           src_b: r_s4_pix.src_b, src_a: r_s4_pix.src_a, oa: r_s4_oa,
                           x: r_s4_pix.x, y: r_s4_pix.y};
            r_s5_nr   <= w_nr[NW-1:0];
            r_s5_ng   <= w_ng[NW-1:0];
            r_s5_nb   <= w_nb[NW-1:0];
        end
    end

    // Divider stages; a zero divisor only shows up on requests that do not mix.
    logic [W-1:0] w_qr;
    logic [W-1:0] w_qg;
    logic [W-1:0] w_qb;

    abp_div u_div_r (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_s5_nr),
        .i_den (r_s5_tail.oa),
        .o_quo (w_qr)
    );

    abp_div u_div_g (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_s5_ng),
        .i_den (r_s5_tail.oa),
        .o_quo (w_qg)
    );

    abp_div u_div_b (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_s5_nb),
        .i_den (r_s5_tail.oa),
        .o_quo (w_qb)
    );

    logic           r_vd   [N];
    abp_pkg::t_tail r_tail [N];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tail[0] <= r_s5_tail;
            for (int i = 1; i < N; i++) begin
                r_tail[i] <= r_tail[i-1];
            end
        end
    end

    // Output register.
    abp_pkg::t_tail w_last;
    logic           w_we;
    logic [W-1:0]   w_r;
    logic [W-1:0]   w_g;
    logic [W-1:0]   w_b;
    logic [W-1:0]   w_a;

    assign w_last = r_tail[N-1];

    always_comb begin
        case (w_last.sel)
            abp_pkg::SEL_RAW: begin
                w_we = 1'b1;
                w_r  = w_last.src_r;
                w_g  = w_last.src_g;
                w_b  = w_last.src_b;
                w_a  = w_last.src_a;
            end
            abp_pkg::SEL_OPAQUE: begin
                w_we = 1'b1;
                w_r  = w_last.src_r;
                w_g  = w_last.src_g;
                w_b  = w_last.src_b;
                w_a  = abp_pkg::ChanMax;
            end
            abp_pkg::SEL_MIX: begin
                w_we = 1'b1;
                w_r  = w_qr;
                w_g  = w_qg;
                w_b  = w_qb;
                w_a  = w_last.oa;
            end
            default: begin
                w_we = 1'b0;
                w_r  = abp_pkg::ChanMin;
                w_g  = abp_pkg::ChanMin;
                w_b  = abp_pkg::ChanMin;
                w_a  = abp_pkg::ChanMin;
            end
        endcase
    end

    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_write_enable <= w_we;
            o_out_r        <= w_r;
            o_out_g        <= w_g;
            o_out_b        <= w_b;
            o_out_a        <= w_a;
            o_out_x        <= w_last.x;
            o_out_y        <= w_last.y;
        end
    end

    // Valid bits advance with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            for (int i = 0; i < N; i++) begin
                r_vd[i] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_v1        <= i_valid;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
            r_v5        <= r_v4;
            r_vd[0]     <= r_v5;
            for (int i = 1; i < N; i++) begin
                r_vd[i] <= r_vd[i-1];
            end
            r_out_valid <= r_vd[N-1];
        end
    end

    assign o_valid = r_out_valid;

endmodule

// File: verif/alpha_blend_pixel_top_test.sv
// Self-checking testbench for alpha_blend_pixel_top: source-over pixel compositing.
// Predicts each write from the request fields and compares in order; uses abp_pkg.
`timescale 1ns / 1ps

module alpha_blend_pixel_top_test;

    localparam int ChanW  = abp_pkg::ChanW;
    localparam int CoordW = abp_pkg::CoordW;

    localparam int QuietLimit = 2000;
    localparam int DrainCycles = 30;
    localparam int RandomPixels = 400;

    typedef struct packed {
        logic              cmd;
        logic [ChanW-1:0]  sr;
        logic [ChanW-1:0]  sg;
        logic [ChanW-1:0]  sb;
        logic [ChanW-1:0]  sa;
        logic [ChanW-1:0]  dr;
        logic [ChanW-1:0]  dg;
        logic [ChanW-1:0]  db;
        logic [ChanW-1:0]  da;
        logic [ChanW-1:0]  cov;
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
    } t_pix_req;

    typedef struct packed {
        logic              we;
        logic [ChanW-1:0]  r;
        logic [ChanW-1:0]  g;
        logic [ChanW-1:0]  b;
        logic [ChanW-1:0]  a;
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
    } t_pix_wr;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic o_stall;
    logic o_valid;
    logic o_write_enable;
    logic [ChanW-1:0]  o_out_r;
    logic [ChanW-1:0]  o_out_g;
    logic [ChanW-1:0]  o_out_b;
    logic [ChanW-1:0]  o_out_a;
    logic [CoordW-1:0] o_out_x;
    logic [CoordW-1:0] o_out_y;

    t_pix_req on_bus = '0;
    t_pix_req pixel_feed[$];
    t_pix_wr  writes_due[$];

    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned feed_gap = 0;
    int unsigned feed_calm = 0;
    int unsigned sink_hold = 0;
    int unsigned sink_calm = 0;

    alpha_blend_pixel_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (on_bus.cmd),
        .i_src_r        (on_bus.sr),
        .i_src_g        (on_bus.sg),
        .i_src_b        (on_bus.sb),
        .i_src_a        (on_bus.sa),
        .i_dst_r        (on_bus.dr),
        .i_dst_g        (on_bus.dg),
        .i_dst_b        (on_bus.db),
        .i_dst_a        (on_bus.da),
        .i_coverage     (on_bus.cov),
        .i_pixel_x      (on_bus.x),
        .i_pixel_y      (on_bus.y),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_write_enable (o_write_enable),
        .o_out_r        (o_out_r),
        .o_out_g        (o_out_g),
        .o_out_b        (o_out_b),
        .o_out_a        (o_out_a),
        .o_out_x        (o_out_x),
        .o_out_y        (o_out_y)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int unsigned mix_chan(int unsigned s, int unsigned d, int unsigned fa,
                                             int unsigned dc, int unsigned oa);
        int unsigned v;
        v = (s * fa + d * dc + oa / 2) / oa;
        return (v > 255) ? 255 : v;
    endfunction

    // Source-over of one request: fade alpha by coverage, then raw, opaque, skip or mix.
    function automatic t_pix_wr source_over(t_pix_req p);
        t_pix_wr w;
        int unsigned sa, cov, fa, dc, oa;
        logic mix;
        w = '0;
        w.x = p.x;
        w.y = p.y;
        sa = 32'(p.sa);
        cov = 32'(p.cov);
        mix = 1'b0;
        fa = 0;
        if (cov == 0) begin
            w.we = 1'b0;
        end else if (p.cmd == abp_pkg::CmdSet && p.cov == abp_pkg::ChanMax) begin
            w.we = 1'b1;
            w.r = p.sr;
            w.g = p.sg;
            w.b = p.sb;
            w.a = p.sa;
        end else if (p.cmd == abp_pkg::CmdBlend && sa == 0) begin
            w.we = 1'b0;
        end else begin
            fa = (sa * cov + 127) / 255;
            mix = 1'b1;
        end
        if (mix && fa == 255) begin
            w.we = 1'b1;
            w.r = p.sr;
            w.g = p.sg;
            w.b = p.sb;
            w.a = abp_pkg::ChanMax;
        end else if (mix && fa != 0) begin
            dc = (32'(p.da) * (255 - fa) + 127) / 255;
            oa = fa + dc;
            w.we = 1'b1;
            w.r = ChanW'(mix_chan(32'(p.sr), 32'(p.dr), fa, dc, oa));
            w.g = ChanW'(mix_chan(32'(p.sg), 32'(p.dg), fa, dc, oa));
            w.b = ChanW'(mix_chan(32'(p.sb), 32'(p.db), fa, dc, oa));
            w.a = (oa > 255) ? abp_pkg::ChanMax : ChanW'(oa);
        end
        return w;
    endfunction

    // Mostly short gaps, a few long ones, and calm stretches with none.
    function automatic int unsigned idle_len(ref int unsigned calm);
        int unsigned r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic int unsigned pick_chan();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0) return 0;
        if (r == 1) return 255;
        return $urandom_range(0, 255);
    endfunction

    function automatic int unsigned pick_coord();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return 0;
        if (r == 1) return 4095;
        return $urandom_range(0, 4095);
    endfunction

    task automatic queue_pixel(input logic cmd,
                               input int unsigned sr, input int unsigned sg,
                               input int unsigned sb, input int unsigned sa,
                               input int unsigned dr, input int unsigned dg,
                               input int unsigned db, input int unsigned da,
                               input int unsigned cov,
                               input int unsigned x, input int unsigned y);
        t_pix_req p;
        p.cmd = cmd;
        p.sr = ChanW'(sr);
        p.sg = ChanW'(sg);
        p.sb = ChanW'(sb);
        p.sa = ChanW'(sa);
        p.dr = ChanW'(dr);
        p.dg = ChanW'(dg);
        p.db = ChanW'(db);
        p.da = ChanW'(da);
        p.cov = ChanW'(cov);
        p.x = CoordW'(x);
        p.y = CoordW'(y);
        pixel_feed = {pixel_feed, p};
    endtask

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    // Driver: hold the request while stalled, advance to the next after a gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (feed_gap > 0) begin
                feed_gap--;
                i_valid <= 1'b0;
            end else if (pixel_feed.size() > 0) begin
                on_bus <= pixel_feed.pop_front();
                i_valid <= 1'b1;
                feed_gap = idle_len(feed_calm);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: check the oldest expected write first, then record a new request.
    always @(posedge i_clk) begin : monitor
        t_pix_wr want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (writes_due.size() == 0) begin
                    $display("%0t: write expected none actual x=%0d y=%0d", $time,
                             o_out_x, o_out_y);
                    mismatch_count++;
                end else begin
                    want = writes_due.pop_front();
                    check_field("write_enable", 32'(want.we), 32'(o_write_enable));
                    check_field("out_r", 32'(want.r), 32'(o_out_r));
                    check_field("out_g", 32'(want.g), 32'(o_out_g));
                    check_field("out_b", 32'(want.b), 32'(o_out_b));
                    check_field("out_a", 32'(want.a), 32'(o_out_a));
                    check_field("out_x", 32'(want.x), 32'(o_out_x));
                    check_field("out_y", 32'(want.y), 32'(o_out_y));
                end
            end
            if (i_valid && !o_stall) begin
                writes_due = {writes_due, source_over(on_bus)};
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QuietLimit) begin
                $display("Mismatches found");
                $finish;
            end
        end
        if (sink_hold > 0) begin
            sink_hold--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            sink_hold = idle_len(sink_calm);
        end
    end

    initial begin
        // coverage zero never writes
        queue_pixel(abp_pkg::CmdSet,   255, 255, 255, 255, 10, 20, 30, 40, 0, 0, 0);
        queue_pixel(abp_pkg::CmdBlend, 255, 255, 255, 255, 10, 20, 30, 40, 0, 4095, 4095);
        // set at full coverage writes raw, even a transparent source
        queue_pixel(abp_pkg::CmdSet,   12, 34, 56, 0, 200, 100, 50, 255, 255, 1, 2);
        queue_pixel(abp_pkg::CmdSet,   255, 255, 255, 255, 0, 0, 0, 0, 255, 4095, 4095);
        queue_pixel(abp_pkg::CmdSet,   90, 180, 45, 128, 1, 2, 3, 200, 255, 7, 9);
        // set at partial coverage goes through the blend path
        queue_pixel(abp_pkg::CmdSet,   200, 100, 50, 255, 10, 20, 30, 128, 128, 100, 200);
        queue_pixel(abp_pkg::CmdSet,   200, 100, 50, 1, 10, 20, 30, 128, 1, 3, 3);
        queue_pixel(abp_pkg::CmdSet,   0, 255, 128, 255, 255, 0, 77, 255, 254, 2048, 2048);
        // blend: transparent, opaque, faded to zero, and mixes
        queue_pixel(abp_pkg::CmdBlend, 100, 150, 200, 0, 10, 20, 30, 40, 255, 5, 6);
        queue_pixel(abp_pkg::CmdBlend, 100, 150, 200, 255, 10, 20, 30, 40, 255, 5, 7);
        queue_pixel(abp_pkg::CmdBlend, 100, 150, 200, 1, 10, 20, 30, 40, 1, 5, 8);
        queue_pixel(abp_pkg::CmdBlend, 100, 150, 200, 128, 10, 20, 30, 0, 255, 5, 9);
        queue_pixel(abp_pkg::CmdBlend, 100, 150, 200, 128, 10, 20, 30, 255, 255, 5, 10);
        queue_pixel(abp_pkg::CmdBlend, 0, 0, 0, 254, 255, 255, 255, 255, 255, 11, 12);
        queue_pixel(abp_pkg::CmdBlend, 255, 255, 255, 1, 0, 0, 0, 0, 255, 13, 14);
        queue_pixel(abp_pkg::CmdBlend, 0, 0, 0, 100, 0, 0, 0, 0, 200, 15, 16);
        queue_pixel(abp_pkg::CmdBlend, 255, 255, 255, 255, 255, 255, 255, 255, 254, 4095, 0);
        queue_pixel(abp_pkg::CmdBlend, 255, 255, 255, 200, 255, 255, 255, 255, 255, 0, 4095);
        queue_pixel(abp_pkg::CmdBlend, 'hAA, 'h55, 'hAA, 'h55, 'h55, 'hAA, 'h55, 'hAA, 'hAA,
                    'hAAA, 'h555);
        queue_pixel(abp_pkg::CmdSet,   'h55, 'hAA, 'h55, 'hAA, 'hAA, 'h55, 'hAA, 'h55, 'h55,
                    'h555, 'hAAA);
        for (int i = 0; i < RandomPixels; i++) begin
            queue_pixel(1'($urandom_range(0, 1)), pick_chan(), pick_chan(), pick_chan(),
                        pick_chan(), pick_chan(), pick_chan(), pick_chan(), pick_chan(),
                        pick_chan(), pick_coord(), pick_coord());
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sample away from the active edge so the driver's updates have settled
        do begin
            @(negedge i_clk);
        end while (pixel_feed.size() != 0 || i_valid || writes_due.size() != 0);
        repeat (DrainCycles) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
